FILE: design/b64_pkg.sv
// Shared types, codes and character tables for the Base64 stream codec.
package b64_pkg;

	localparam int unsigned JOB_Q_DEPTH = 2;
	localparam int unsigned JOB_Q_PTR_W = $clog2(JOB_Q_DEPTH);
	localparam int unsigned JOB_Q_CNT_W = $clog2(JOB_Q_DEPTH + 1);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_BAD_CHAR    = 2'd1;
	localparam logic [1:0] ERR_AFTER_FLUSH = 2'd2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [1:0] error;
	} out_item_t;

	// One decoded item's worth of results: count is 1..4, bytes[0] goes first.
	typedef struct packed {
		logic [2:0]      count;
		logic [3:0][7:0] bytes;
		logic [1:0]      error;
	} job_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2B;
		end else begin
			c = 8'h2F;
		end
		return c;
	endfunction

	function automatic sextet_t dec_char(input logic [7:0] c);
		sextet_t s;
		s.valid = 1'b1;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			s.value = 6'd62;
		end else if (c == 8'h2F) begin
			s.value = 6'd63;
		end else begin
			s.valid = 1'b0;
			s.value = 6'd0;
		end
		return s;
	endfunction

endpackage

FILE: design/base64_stream_codec_unit.sv
// Top level of the Base64 stream codec: front end, job queue and result sequencer.
// Each job is queued, then loaded into the sequencer, before its first result is offered.
// Throughput: one item per cycle while the job queue has room; results leave one per
// cycle while result_stall is low, so the result port (up to four results per item)
// sets the sustained rate. Reset (arst_n low, asynchronous): encode mode, empty buffer,
// stream not flushed, queue and result register empty.
module base64_stream_codec_unit (
	input  logic               clk,
	input  logic               arst_n,
	// configuration: bit 0 of cfg_data is encode_mode
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  b64_pkg::in_item_t  item,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output b64_pkg::out_item_t result
);

	logic          item_take;
	logic          job_push;
	b64_pkg::job_t new_job;
	b64_pkg::job_t head_job;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;

	// The user must make config writes only when idle; nothing enforces it. The port is always open.
	assign cfg_ready = 1'b1;

	// The front end stalls only on a full queue; an item that makes no
	// result waits then too, which keeps the check simple.
	assign item_stall = q_full;
	assign item_take  = item_valid && !q_full;

	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_mode  (cfg_data),
		.item_take (item_take),
		.item      (item),
		.job_push  (job_push),
		.job       (new_job)
	);

	b64_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (new_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Sequencer holds the current job in registers; its output stays
	// steady while result_stall is high.
	b64_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: design/b64_front.sv
// Front end: takes items, keeps the bit buffer and builds result jobs.
module b64_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_mode,
	input  logic             item_take,
	input  b64_pkg::in_item_t item,
	output logic             job_push,
	output b64_pkg::job_t    job
);

	logic        encode_mode_q;
	logic [23:0] bit_buffer_q;
	logic [1:0]  fill_count_q;
	logic        stream_done_q;

	logic [23:0]      buf_next;
	logic [1:0]       fill_next;
	logic             done_next;
	logic [1:0]       fill_enc;
	logic [23:0]      enc_buf;
	logic [23:0]      dec_buf;
	b64_pkg::sextet_t sx;

	always_comb begin
		fill_enc = (fill_count_q == 2'd3) ? 2'd2 : fill_count_q;
		case (fill_enc)
			2'd0:    enc_buf = bit_buffer_q | {item.data_byte, 16'h0};
			2'd1:    enc_buf = bit_buffer_q | {8'h0, item.data_byte, 8'h0};
			default: enc_buf = bit_buffer_q | {16'h0, item.data_byte};
		endcase
		sx = b64_pkg::dec_char(item.data_byte);
		case (fill_count_q)
			2'd0:    dec_buf = bit_buffer_q | {sx.value, 18'h0};
			2'd1:    dec_buf = bit_buffer_q | {6'h0, sx.value, 12'h0};
			2'd2:    dec_buf = bit_buffer_q | {12'h0, sx.value, 6'h0};
			default: dec_buf = bit_buffer_q | {18'h0, sx.value};
		endcase
	end

	always_comb begin
		buf_next  = bit_buffer_q;
		fill_next = fill_count_q;
		done_next = stream_done_q;
		job       = '0;
		job.error = b64_pkg::ERR_NONE;
		if (item.op == b64_pkg::OP_FLUSH) begin
			if (!stream_done_q) begin
				done_next = 1'b1;
				buf_next  = '0;
				fill_next = '0;
				if (encode_mode_q) begin
					job.bytes[0] = b64_pkg::enc_char(bit_buffer_q[23:18]);
					job.bytes[1] = b64_pkg::enc_char(bit_buffer_q[17:12]);
					job.bytes[2] = (fill_count_q == 2'd2)
						? b64_pkg::enc_char(bit_buffer_q[11:6]) : b64_pkg::PAD_CHAR;
					job.bytes[3] = b64_pkg::PAD_CHAR;
					if (fill_count_q == 2'd1 || fill_count_q == 2'd2) begin
						job.count = 3'd4;
					end
				end else begin
					job.bytes[0] = bit_buffer_q[23:16];
					job.bytes[1] = bit_buffer_q[15:8];
					if (fill_count_q == 2'd2) begin
						job.count = 3'd1;
					end else if (fill_count_q == 2'd3) begin
						job.count = 3'd2;
					end
				end
			end
		end else if (stream_done_q) begin
			job.count = 3'd1;
			job.error = b64_pkg::ERR_AFTER_FLUSH;
		end else if (encode_mode_q) begin
			if (fill_enc == 2'd2) begin
				job.count    = 3'd4;
				job.bytes[0] = b64_pkg::enc_char(enc_buf[23:18]);
				job.bytes[1] = b64_pkg::enc_char(enc_buf[17:12]);
				job.bytes[2] = b64_pkg::enc_char(enc_buf[11:6]);
				job.bytes[3] = b64_pkg::enc_char(enc_buf[5:0]);
				buf_next     = '0;
				fill_next    = '0;
			end else begin
				buf_next  = enc_buf;
				fill_next = fill_enc + 2'd1;
			end
		end else if (item.data_byte != b64_pkg::PAD_CHAR) begin
			if (!sx.valid) begin
				job.count = 3'd1;
				job.error = b64_pkg::ERR_BAD_CHAR;
			end else if (fill_count_q == 2'd3) begin
				job.count    = 3'd3;
				job.bytes[0] = dec_buf[23:16];
				job.bytes[1] = dec_buf[15:8];
				job.bytes[2] = dec_buf[7:0];
				buf_next     = '0;
				fill_next    = '0;
			end else begin
				buf_next  = dec_buf;
				fill_next = fill_count_q + 2'd1;
			end
		end
	end

	// items with no results leave nothing in the queue
	assign job_push = item_take && (job.count != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_mode_q <= 1'b1;
			bit_buffer_q  <= '0;
			fill_count_q  <= '0;
			stream_done_q <= 1'b0;
		end else if (cfg_we) begin
			encode_mode_q <= cfg_mode;
			bit_buffer_q  <= '0;
			fill_count_q  <= '0;
		end else if (item_take) begin
			bit_buffer_q  <= buf_next;
			fill_count_q  <= fill_next;
			stream_done_q <= done_next;
		end
	end

endmodule

FILE: design/b64_queue.sv
// Short job queue between the front end and the result sequencer.
module b64_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  b64_pkg::job_t push_job,
	input  logic          pop,
	output b64_pkg::job_t head_job,
	output logic          full,
	output logic          empty
);

	b64_pkg::job_t                         slot_q [b64_pkg::JOB_Q_DEPTH];
	logic [b64_pkg::JOB_Q_PTR_W-1:0]       wr_ptr_q;
	logic [b64_pkg::JOB_Q_PTR_W-1:0]       rd_ptr_q;
	logic [b64_pkg::JOB_Q_CNT_W-1:0]       count_q;

	assign full     = (count_q == b64_pkg::JOB_Q_CNT_W'(b64_pkg::JOB_Q_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == b64_pkg::JOB_Q_PTR_W'(b64_pkg::JOB_Q_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == b64_pkg::JOB_Q_PTR_W'(b64_pkg::JOB_Q_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/b64_back.sv
// Back end: walks each job and hands out one result per transaction.
module b64_back (
	input  logic               clk,
	input  logic               arst_n,
	input  b64_pkg::job_t      head_job,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               result_valid,
	input  logic               result_stall,
	output b64_pkg::out_item_t result
);

	b64_pkg::job_t cur_q;
	logic          busy_q;
	logic [1:0]    idx_q;
	logic          is_last;
	logic          taken;

	assign is_last = ({1'b0, idx_q} == (cur_q.count - 3'd1));
	assign taken   = busy_q && !result_stall;
	assign q_pop   = !q_empty && (!busy_q || (taken && is_last));

	assign result_valid    = busy_q;
	assign result.out_byte = cur_q.bytes[idx_q];
	assign result.last     = is_last;
	assign result.error    = cur_q.error;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= head_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (taken) begin
			if (is_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

FILE: tb/base64_stream_codec_unit_test.sv
// Self-checking testbench for the Base64 stream codec: directed table, random streams, predictor.
module base64_stream_codec_unit_test;

	localparam logic MODE_DECODE = 1'b0;
	localparam logic MODE_ENCODE = 1'b1;

	localparam int SETTLE_CYCLES    = 8;      // covers items that leave no result
	localparam int END_CYCLES       = 20;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int HOLD_AFTER_ITEMS = 200;
	localparam int HOLD_CYCLES      = 300;
	localparam int REPORT_LIMIT     = 10;
	localparam int N_PHASES         = 7;
	// encode, decode, encode, decode, decode, encode; the last phase picks at random
	localparam logic [5:0] PHASE_MODES = 6'b100101;

	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One table row. typed rows carry their results; the rest go through the predictor.
	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic [7:0]  data;
		logic        typed;
		logic [2:0]  n;
		logic [31:0] bytes;   // first result in bits 31:24
		logic [1:0]  err;
	} row_t;

	typedef struct packed {
		logic [2:0]                n;
		b64_pkg::out_item_t [3:0]  r;
	} codec_result_t;

	// Flush is terminal until reset, so the flush rows run after the random part.
	localparam int TAIL_ROW = 25;
	localparam int N_ROWS   = 29;
	localparam row_t DIR_ROWS [N_ROWS] = '{
		// encode mode straight out of reset: all-zero and all-one groups
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h00, 1'b1, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h00, 1'b1, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h00, 1'b1, 3'd4, 32'h41414141, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'hFF, 1'b1, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'hFF, 1'b1, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'hFF, 1'b1, 3'd4, 32'h2F2F2F2F, b64_pkg::ERR_NONE},
		// two bytes left held, then dropped by the mode switch
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h4D, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h61, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_CFG,  b64_pkg::OP_WRITE, {7'd0, MODE_DECODE}, 1'b0, 3'd0, 32'h0,
			b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h54, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h57, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h46, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h75, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		// padding is skipped, bad characters error out without touching state
		'{ROW_ITEM, b64_pkg::OP_WRITE, b64_pkg::PAD_CHAR, 1'b1, 3'd0, 32'h0,
			b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h00, 1'b1, 3'd1, 32'h0, b64_pkg::ERR_BAD_CHAR},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'hFF, 1'b1, 3'd1, 32'h0, b64_pkg::ERR_BAD_CHAR},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h40, 1'b1, 3'd1, 32'h0, b64_pkg::ERR_BAD_CHAR},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h7A, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h2B, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h2F, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h39, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h30, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h5A, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_CFG,  b64_pkg::OP_WRITE, {7'd0, MODE_ENCODE}, 1'b0, 3'd0, 32'h0,
			b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h80, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		// tail: flush, write after flush, repeat flush, write again
		'{ROW_ITEM, b64_pkg::OP_FLUSH, 8'hA5, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'hFF, 1'b1, 3'd1, 32'h0, b64_pkg::ERR_AFTER_FLUSH},
		'{ROW_ITEM, b64_pkg::OP_FLUSH, 8'h00, 1'b1, 3'd0, 32'h0, b64_pkg::ERR_NONE},
		'{ROW_ITEM, b64_pkg::OP_WRITE, 8'h00, 1'b1, 3'd1, 32'h0, b64_pkg::ERR_AFTER_FLUSH}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;
	logic               item_valid;
	logic               item_stall;
	b64_pkg::in_item_t  item;
	logic               result_valid;
	logic               result_stall = 1'b0;
	b64_pkg::out_item_t result;

	// predictor state
	logic        pred_encode;
	logic [23:0] pred_bits;
	logic [1:0]  pred_fill;
	logic        pred_done;

	b64_pkg::out_item_t expected_results [$];
	int        mismatches  = 0;
	int        items_in    = 0;
	int        cycle_count = 0;
	int        hold_left   = 0;
	bit        hold_used   = 1'b0;
	bit        quiet       = 1'b0;

	base64_stream_codec_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] b64_char(logic [5:0] v);
		return B64_ALPHABET[8*(63 - int'(v)) +: 8];
	endfunction

	function automatic int char_sextet(logic [7:0] c);
		for (int i = 0; i < 64; i++) begin
			if (b64_char(6'(i)) == c) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void add_result(inout codec_result_t s, input logic [7:0] b,
			input logic [1:0] e);
		s.r[s.n] = '{out_byte: b, last: 1'b0, error: e};
		s.n = s.n + 3'd1;
	endfunction

	// Advances the predictor by one item and returns the results it causes.
	function automatic codec_result_t codec_predict(b64_pkg::in_item_t it);
		codec_result_t s;
		int f;
		int v;
		s = '0;
		f = int'(pred_fill);
		if (it.op == b64_pkg::OP_FLUSH) begin
			if (pred_done) begin
				return s;
			end
			pred_done = 1'b1;
			if (pred_encode) begin
				if (f == 1 || f == 2) begin
					add_result(s, b64_char(pred_bits[23:18]), b64_pkg::ERR_NONE);
					add_result(s, b64_char(pred_bits[17:12]), b64_pkg::ERR_NONE);
					add_result(s,
						(f == 2) ? b64_char(pred_bits[11:6]) : b64_pkg::PAD_CHAR,
						b64_pkg::ERR_NONE);
					add_result(s, b64_pkg::PAD_CHAR, b64_pkg::ERR_NONE);
				end
			end else begin
				if (f >= 2) begin
					add_result(s, pred_bits[23:16], b64_pkg::ERR_NONE);
				end
				if (f == 3) begin
					add_result(s, pred_bits[15:8], b64_pkg::ERR_NONE);
				end
			end
			pred_bits = '0;
			pred_fill = '0;
		end else if (pred_done) begin
			add_result(s, 8'h00, b64_pkg::ERR_AFTER_FLUSH);
		end else if (pred_encode) begin
			pred_bits[23 - 8*f -: 8] = it.data_byte;
			if (f == 2) begin
				add_result(s, b64_char(pred_bits[23:18]), b64_pkg::ERR_NONE);
				add_result(s, b64_char(pred_bits[17:12]), b64_pkg::ERR_NONE);
				add_result(s, b64_char(pred_bits[11:6]), b64_pkg::ERR_NONE);
				add_result(s, b64_char(pred_bits[5:0]), b64_pkg::ERR_NONE);
				pred_bits = '0;
				pred_fill = '0;
			end else begin
				pred_fill = pred_fill + 2'd1;
			end
		end else if (it.data_byte != b64_pkg::PAD_CHAR) begin
			v = char_sextet(it.data_byte);
			if (v < 0) begin
				add_result(s, 8'h00, b64_pkg::ERR_BAD_CHAR);
			end else begin
				pred_bits[23 - 6*f -: 6] = 6'(v);
				if (f == 3) begin
					add_result(s, pred_bits[23:16], b64_pkg::ERR_NONE);
					add_result(s, pred_bits[15:8], b64_pkg::ERR_NONE);
					add_result(s, pred_bits[7:0], b64_pkg::ERR_NONE);
					pred_bits = '0;
					pred_fill = '0;
				end else begin
					pred_fill = pred_fill + 2'd1;
				end
			end
		end
		if (s.n != 0) begin
			s.r[s.n - 3'd1].last = 1'b1;
		end
		return s;
	endfunction

	// Mostly alphabet text, some padding, the rest any byte at all.
	function automatic logic [7:0] random_text_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			return b64_char(6'($urandom_range(63)));
		end
		if (pick < 80) begin
			return b64_pkg::PAD_CHAR;
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endfunction

	// Offers one item, waits for its transaction, then queues what it should produce.
	task automatic send_item(b64_pkg::in_item_t it, bit typed, logic [2:0] n,
			logic [31:0] bytes, logic [1:0] err);
		codec_result_t pr;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 30) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		items_in++;
		pr = codec_predict(it);
		if (typed) begin
			pr.n = n;
			for (int k = 0; k < int'(n); k++) begin
				pr.r[k] = '{out_byte: bytes[31 - 8*k -: 8], last: (k == int'(n) - 1),
					error: err};
			end
		end
		for (int k = 0; k < int'(pr.n); k++) begin
			expected_results.push_back(pr.r[k]);
		end
	endtask

	// Mode writes only go in once the codec has drained.
	task automatic write_mode(logic mode);
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		pred_encode = mode;
		pred_bits   = '0;
		pred_fill   = '0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_rows(int first, int stop);
		b64_pkg::in_item_t it;
		for (int i = first; i < stop; i++) begin
			if (DIR_ROWS[i].kind == ROW_CFG) begin
				write_mode(DIR_ROWS[i].data[0]);
			end else begin
				it.op        = DIR_ROWS[i].op;
				it.data_byte = DIR_ROWS[i].data;
				send_item(it, DIR_ROWS[i].typed, DIR_ROWS[i].n, DIR_ROWS[i].bytes,
					DIR_ROWS[i].err);
			end
		end
	endtask

	// Receiver: random stalls, one long hold-off once the stream is well under way.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (!hold_used && items_in >= HOLD_AFTER_ITEMS) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !quiet && ($urandom_range(99) < 30);
		end
	end

	always @(posedge clk) begin : result_check
		b64_pkg::out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result: byte %h last %b error %0d",
					result.out_byte, result.last, result.error));
			end else begin
				want = expected_results.pop_front();
				if (result.out_byte !== want.out_byte || result.last !== want.last ||
						result.error !== want.error) begin
					note_mismatch($sformatf(
						"result mismatch: byte %h/%h last %b/%b error %0d/%0d (exp/act)",
						want.out_byte, result.out_byte, want.last, result.last,
						want.error, result.error));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		b64_pkg::in_item_t it;
		logic     mode;
		int       n_items;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = MODE_ENCODE;
		item_valid  = 1'b0;
		item        = '0;
		pred_encode = MODE_ENCODE;
		pred_bits   = '0;
		pred_fill   = '0;
		pred_done   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_rows(0, TAIL_ROW);

		// random streams, one mode per phase; the third phase runs without any idling
		for (int phase = 0; phase < N_PHASES; phase++) begin
			mode  = (phase < 6) ? PHASE_MODES[phase] : 1'($urandom_range(1));
			quiet = (phase == 2);
			write_mode(mode);
			n_items = $urandom_range(42, 55);
			repeat (n_items) begin
				it.op        = b64_pkg::OP_WRITE;
				it.data_byte = (mode == MODE_ENCODE) ? 8'($urandom_range(255))
					: random_text_char();
				send_item(it, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE);
			end
		end
		quiet = 1'b0;

		// the first flush of the run lands on whatever the last stream left held
		run_rows(TAIL_ROW, N_ROWS);
		repeat (16) begin
			it.op        = 1'($urandom_range(1));
			it.data_byte = 8'($urandom_range(255));
			send_item(it, 1'b0, 3'd0, 32'h0, b64_pkg::ERR_NONE);
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (END_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
